FILE: design/ctc_pkg.sv
// Shared types, constants and arithmetic steps for the tower centroid block.
// No dependencies; the front, back and top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package ctc_pkg;

  localparam int NUM_TOWERS      = 8;
  localparam int SIDE_TOWERS     = 4;
  localparam int SQRT_STAGES     = 8;
  localparam int SQRT_STEPS      = 2;
  localparam int NUM_QUANT       = 4;
  localparam int DIV_STAGES      = 3;
  localparam int DIV_STEPS       = 3;
  localparam int Q_BITS          = 9;
  localparam logic [27:0] NUM_SCALE = 28'd896;

  typedef struct packed {
    logic [19:0] rem;
    logic [15:0] root;
    logic [15:0] rad;
  } sq_t;

  typedef struct packed {
    logic [17:0]        den;
    logic signed [18:0] dx;
    logic signed [18:0] dy;
  } side_sum_t;

  typedef struct packed {
    side_sum_t c;
    side_sum_t a;
  } mid_item_t;

  typedef struct packed {
    logic [27:0]       num;
    logic [17:0]       den;
    logic [Q_BITS-1:0] q;
    logic              neg;
  } div_t;

  typedef struct packed {
    logic signed [9:0] x;
    logic signed [9:0] y;
    logic              valid;
  } side_res_t;

  typedef struct packed {
    side_res_t c;
    side_res_t a;
  } out_item_t;

  // One bit of an integer square root, consuming two radicand bits.
  function automatic sq_t sqrt_step(sq_t a);
    sq_t         res;
    logic [19:0] r;
    logic [19:0] trial;
    r     = {a.rem[17:0], a.rad[15:14]};
    trial = {2'b00, a.root, 2'b01};
    res.rad = {a.rad[13:0], 2'b00};
    if (r >= trial) begin
      res.rem  = r - trial;
      res.root = {a.root[14:0], 1'b1};
    end else begin
      res.rem  = r;
      res.root = {a.root[14:0], 1'b0};
    end
    return res;
  endfunction

  // One quotient bit of a restoring division by twice the weight sum.
  function automatic div_t div_step(div_t a, int b);
    div_t        res;
    logic [27:0] sh;
    res = a;
    sh  = 28'({a.den, 1'b0}) << b;
    if (a.num >= sh) begin
      res.num = a.num - sh;
      res.q   = {a.q[Q_BITS-2:0], 1'b1};
    end else begin
      res.q   = {a.q[Q_BITS-2:0], 1'b0};
    end
    return res;
  endfunction

  function automatic side_sum_t side_sum(logic [15:0] w0, logic [15:0] w1,
                                         logic [15:0] w2, logic [15:0] w3);
    side_sum_t   s;
    logic [17:0] px;
    logic [17:0] nx;
    logic [17:0] py;
    logic [17:0] ny;
    px = 18'(w1) + 18'(w3);
    nx = 18'(w0) + 18'(w2);
    py = 18'(w2) + 18'(w3);
    ny = 18'(w0) + 18'(w1);
    s.den = px + nx;
    s.dx  = $signed({1'b0, px}) - $signed({1'b0, nx});
    s.dy  = $signed({1'b0, py}) - $signed({1'b0, ny});
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: design/ctc_fifo.sv
// Small synchronous queue built from registers, first word shown at the head.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ctc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] dout,
  output logic                  empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  assign dout  = mem_r[rd_ptr_r];
  assign empty = (cnt_r == '0);

endmodule

`default_nettype wire

FILE: design/ctc_front.sv
// Front part: pipelined square roots of all eight towers, then per-side sums.
// Depends on ctc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctc_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_acc,
  input  wire logic [15:0]        tower [8],
  output logic                    mid_vld,
  output ctc_pkg::mid_item_t      mid_item
);

  import ctc_pkg::*;

  sq_t                    st_r   [SQRT_STAGES][NUM_TOWERS];
  sq_t                    st_nxt [SQRT_STAGES][NUM_TOWERS];
  logic [SQRT_STAGES-1:0] vld_r;
  logic                   mid_vld_r;
  mid_item_t              mid_item_r, mid_item_nxt;

  always_comb begin
    sq_t cur;
    for (int s = 0; s < SQRT_STAGES; s++) begin
      for (int t = 0; t < NUM_TOWERS; t++) begin
        if (s == 0) begin
          cur = '{rem: '0, root: '0, rad: tower[t]};
        end else begin
          cur = st_r[s-1][t];
        end
        for (int k = 0; k < SQRT_STEPS; k++) begin
          cur = sqrt_step(cur);
        end
        st_nxt[s][t] = cur;
      end
    end
  end

  always_comb begin
    mid_item_nxt.c = side_sum(st_r[SQRT_STAGES-1][0].root, st_r[SQRT_STAGES-1][1].root,
                              st_r[SQRT_STAGES-1][2].root, st_r[SQRT_STAGES-1][3].root);
    mid_item_nxt.a = side_sum(st_r[SQRT_STAGES-1][4].root, st_r[SQRT_STAGES-1][5].root,
                              st_r[SQRT_STAGES-1][6].root, st_r[SQRT_STAGES-1][7].root);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      mid_vld_r <= 1'b0;
    end else begin
      vld_r     <= {vld_r[SQRT_STAGES-2:0], in_acc};
      mid_vld_r <= vld_r[SQRT_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    st_r       <= st_nxt;
    mid_item_r <= mid_item_nxt;
  end

  assign mid_vld  = mid_vld_r;
  assign mid_item = mid_item_r;

endmodule

`default_nettype wire

FILE: design/ctc_back.sv
// Back part: scaled, rounded division of the position sums by the weight sums.
// Depends on ctc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctc_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               bk_vld,
  input  wire ctc_pkg::mid_item_t bk_item,
  output logic                    res_vld,
  output ctc_pkg::out_item_t      res_item
);

  import ctc_pkg::*;

  div_t                  p_r    [NUM_QUANT];
  div_t                  p_nxt  [NUM_QUANT];
  div_t                  d_r    [DIV_STAGES][NUM_QUANT];
  div_t                  d_nxt  [DIV_STAGES][NUM_QUANT];
  logic [1:0]            psv_r, psv_nxt;
  logic [1:0]            dsv_r  [DIV_STAGES];
  logic [DIV_STAGES:0]   vld_r;
  logic                  res_vld_r;
  out_item_t             res_r, res_nxt;

  always_comb begin
    logic signed [18:0] d;
    logic [17:0]        den;
    logic [17:0]        mag;
    for (int q = 0; q < NUM_QUANT; q++) begin
      unique case (q)
        0: begin d = bk_item.c.dx; den = bk_item.c.den; end
        1: begin d = bk_item.c.dy; den = bk_item.c.den; end
        2: begin d = bk_item.a.dx; den = bk_item.a.den; end
        default: begin d = bk_item.a.dy; den = bk_item.a.den; end
      endcase
      mag = d[18] ? 18'(-d) : 18'(d);
      p_nxt[q].neg = d[18];
      p_nxt[q].den = den;
      p_nxt[q].q   = '0;
      p_nxt[q].num = 28'(mag) * NUM_SCALE + 28'(den);
    end
    psv_nxt = {bk_item.a.den != '0, bk_item.c.den != '0};
  end

  always_comb begin
    div_t cur;
    for (int s = 0; s < DIV_STAGES; s++) begin
      for (int q = 0; q < NUM_QUANT; q++) begin
        cur = (s == 0) ? p_r[q] : d_r[s-1][q];
        for (int k = 0; k < DIV_STEPS; k++) begin
          cur = div_step(cur, Q_BITS - 1 - (s * DIV_STEPS + k));
        end
        d_nxt[s][q] = cur;
      end
    end
  end

  always_comb begin
    logic signed [9:0] v [NUM_QUANT];
    for (int q = 0; q < NUM_QUANT; q++) begin
      v[q] = d_r[DIV_STAGES-1][q].neg ? -$signed({1'b0, d_r[DIV_STAGES-1][q].q})
                                      : $signed({1'b0, d_r[DIV_STAGES-1][q].q});
    end
    res_nxt.c.valid = dsv_r[DIV_STAGES-1][0];
    res_nxt.a.valid = dsv_r[DIV_STAGES-1][1];
    res_nxt.c.x     = res_nxt.c.valid ? v[0] : '0;
    res_nxt.c.y     = res_nxt.c.valid ? v[1] : '0;
    res_nxt.a.x     = res_nxt.a.valid ? v[2] : '0;
    res_nxt.a.y     = res_nxt.a.valid ? v[3] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      res_vld_r <= 1'b0;
    end else begin
      vld_r     <= {vld_r[DIV_STAGES-1:0], bk_vld};
      res_vld_r <= vld_r[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    p_r      <= p_nxt;
    psv_r    <= psv_nxt;
    d_r      <= d_nxt;
    dsv_r[0] <= psv_r;
    for (int s = 1; s < DIV_STAGES; s++) begin
      dsv_r[s] <= dsv_r[s-1];
    end
    res_r    <= res_nxt;
  end

  assign res_vld  = res_vld_r;
  assign res_item = res_r;

endmodule

`default_nettype wire

FILE: design/calorimeter_tower_centroid.sv
// Top level of the tower centroid block: front, middle queue, back, output queue.
// Depends on ctc_pkg, ctc_front, ctc_back and ctc_fifo.
//
//   channel  | direction | handshake        | payload
//   in_      | input     | in_valid/in_stall   | eight 16-bit tower energies
//   out_     | output    | out_valid/out_stall | x, y, valid for sides C and A
//
// One item is accepted per cycle while in_stall is low; each result passes through
// the eight-stage square root pipeline, the sum stage, the middle queue and the
// five-stage divider pipeline.
// Reset clears the pipeline valid bits, queue pointers and credit counters only.
// Input stall is raised when the middle queue has no free slot for items in flight;
// output stall holds results in the output queue and backs up into the middle one.
`timescale 1ns / 1ps
`default_nettype none

module calorimeter_tower_centroid #(
  parameter int MID_DEPTH = 16,
  parameter int OUT_DEPTH = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [15:0]       in_tower_c0,
  input  wire logic [15:0]       in_tower_c1,
  input  wire logic [15:0]       in_tower_c2,
  input  wire logic [15:0]       in_tower_c3,
  input  wire logic [15:0]       in_tower_a0,
  input  wire logic [15:0]       in_tower_a1,
  input  wire logic [15:0]       in_tower_a2,
  input  wire logic [15:0]       in_tower_a3,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic signed [9:0]      out_side_c_x,
  output logic signed [9:0]      out_side_c_y,
  output logic                   out_side_c_valid,
  output logic signed [9:0]      out_side_a_x,
  output logic signed [9:0]      out_side_a_y,
  output logic                   out_side_a_valid
);

  import ctc_pkg::*;

  localparam int FCW = $clog2(MID_DEPTH + 1);
  localparam int BCW = $clog2(OUT_DEPTH + 1);

  logic [15:0] tower [NUM_TOWERS];
  logic        in_acc, out_acc;
  logic        mid_vld, mid_empty, mid_pop;
  mid_item_t   mid_item, mid_head;
  logic        res_vld, out_empty;
  out_item_t   res_item, out_head;
  logic [FCW-1:0] f_cnt_r, f_cnt_nxt;
  logic [BCW-1:0] b_cnt_r, b_cnt_nxt;

  assign tower[0] = in_tower_c0;
  assign tower[1] = in_tower_c1;
  assign tower[2] = in_tower_c2;
  assign tower[3] = in_tower_c3;
  assign tower[4] = in_tower_a0;
  assign tower[5] = in_tower_a1;
  assign tower[6] = in_tower_a2;
  assign tower[7] = in_tower_a3;

  assign in_stall  = (f_cnt_r == FCW'(MID_DEPTH));
  assign in_acc    = in_valid && !in_stall;
  assign mid_pop   = !mid_empty && (b_cnt_r != BCW'(OUT_DEPTH));
  assign out_valid = !out_empty;
  assign out_acc   = out_valid && !out_stall;

  always_comb begin
    f_cnt_nxt = f_cnt_r;
    b_cnt_nxt = b_cnt_r;
    if (in_acc && !mid_pop) begin
      f_cnt_nxt = f_cnt_r + FCW'(1);
    end else if (mid_pop && !in_acc) begin
      f_cnt_nxt = f_cnt_r - FCW'(1);
    end
    if (mid_pop && !out_acc) begin
      b_cnt_nxt = b_cnt_r + BCW'(1);
    end else if (out_acc && !mid_pop) begin
      b_cnt_nxt = b_cnt_r - BCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_cnt_r <= '0;
      b_cnt_r <= '0;
    end else begin
      f_cnt_r <= f_cnt_nxt;
      b_cnt_r <= b_cnt_nxt;
    end
  end

  ctc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_acc   (in_acc),
    .tower    (tower),
    .mid_vld  (mid_vld),
    .mid_item (mid_item)
  );

  ctc_fifo #(
    .WIDTH ($bits(mid_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_vld),
    .din   (mid_item),
    .pop   (mid_pop),
    .dout  (mid_head),
    .empty (mid_empty)
  );

  ctc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .bk_vld   (mid_pop),
    .bk_item  (mid_head),
    .res_vld  (res_vld),
    .res_item (res_item)
  );

  ctc_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_vld),
    .din   (res_item),
    .pop   (out_acc),
    .dout  (out_head),
    .empty (out_empty)
  );

  assign out_side_c_x     = out_head.c.x;
  assign out_side_c_y     = out_head.c.y;
  assign out_side_c_valid = out_head.c.valid;
  assign out_side_a_x     = out_head.a.x;
  assign out_side_a_y     = out_head.a.y;
  assign out_side_a_valid = out_head.a.valid;

endmodule

`default_nettype wire

FILE: design/ctc_checker.sv
// Port-level checks of the tower centroid block, bound to its top level.
// Depends on calorimeter_tower_centroid.
`timescale 1ns / 1ps
`default_nettype none

module ctc_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic signed [9:0] out_side_c_x,
  input wire logic signed [9:0] out_side_c_y,
  input wire logic              out_side_c_valid,
  input wire logic signed [9:0] out_side_a_x,
  input wire logic signed [9:0] out_side_a_y,
  input wire logic              out_side_a_valid
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("Result valid dropped while stalled.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_side_c_x) && $stable(out_side_c_y) &&
      $stable(out_side_a_x) && $stable(out_side_a_y))
    else $error("Stalled result changed.");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_side_c_valid || (out_side_c_x == 0 && out_side_c_y == 0)) &&
      (out_side_a_valid || (out_side_a_x == 0 && out_side_a_y == 0)))
    else $error("Empty side has a nonzero centroid.");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_side_c_x <= 448 && out_side_c_x >= -448 &&
      out_side_c_y <= 448 && out_side_c_y >= -448 &&
      out_side_a_x <= 448 && out_side_a_x >= -448 &&
      out_side_a_y <= 448 && out_side_a_y >= -448)
    else $error("Centroid outside the tower span.");

endmodule

bind calorimeter_tower_centroid ctc_checker u_ctc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_side_c_x     (out_side_c_x),
  .out_side_c_y     (out_side_c_y),
  .out_side_c_valid (out_side_c_valid),
  .out_side_a_x     (out_side_a_x),
  .out_side_a_y     (out_side_a_y),
  .out_side_a_valid (out_side_a_valid)
);

`default_nettype wire
